>>> rtl/core/kscle_pkg.sv
// shared types, codes and key maps for the scan code line editor
package kscle_pkg;

  // fixed field widths
  localparam int unsigned CharW  = 7;
  localparam int unsigned MaxW   = 7;
  localparam int unsigned LenW   = 6;
  localparam int unsigned KindW  = 2;

  // command queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // scan code constants
  localparam logic [7:0] SC_BREAK_BIT = 8'h80;
  localparam logic [6:0] SC_LSHIFT    = 7'h2A;
  localparam logic [6:0] SC_RSHIFT    = 7'h36;
  localparam logic [6:0] SC_CTRL      = 7'h1D;
  localparam logic [6:0] SC_ALT       = 7'h38;
  localparam logic [6:0] SC_CAPS      = 7'h3A;
  localparam int unsigned MapSize     = 58;

  // special characters
  localparam logic [CharW-1:0] CH_NONE  = 7'h00;
  localparam logic [CharW-1:0] CH_BKSP  = 7'h08;
  localparam logic [CharW-1:0] CH_ENTER = 7'h0A;

  // result kinds
  localparam logic [KindW-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KindW-1:0] KIND_CMD    = 2'd1;
  localparam logic [KindW-1:0] KIND_STATUS = 2'd2;

  // commands passed from front to back
  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_BKSP,
    CMD_ENTER,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    cmd_e             op;
    logic [CharW-1:0] char_code;
    logic [MaxW-1:0]  max_length;
  } cmd_t;

  // unshifted key map, indexed by make code
  localparam logic [CharW-1:0] PLAIN_MAP [MapSize] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
    7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
    7'h70, 7'h5B, 7'h5D, 7'h0A,
    7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
    7'h3B, 7'h27, 7'h60,
    7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00,
    7'h2A, 7'h00, 7'h20
  };

  // shifted key map, used with shift held or caps lock on
  localparam logic [CharW-1:0] SHIFT_MAP [MapSize] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
    7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
    7'h50, 7'h7B, 7'h7D, 7'h0A,
    7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
    7'h3A, 7'h22, 7'h7E,
    7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00,
    7'h2A, 7'h00, 7'h20
  };

endpackage

>>> rtl/core/kscle_front.sv
// front end: accepts beats, tracks shift and caps lock, maps keys to commands
module kscle_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [7:0]                  scan_code_i,
  input  logic [kscle_pkg::MaxW-1:0]  max_length_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output kscle_pkg::cmd_t             q_cmd_o
);
  import kscle_pkg::*;

  logic             shift_q, shift_d;
  logic             caps_q, caps_d;
  logic             accept;
  logic [6:0]       code7;
  logic [CharW-1:0] map_ch;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign code7      = scan_code_i[6:0];

  // key map lookup
  always_comb begin
    map_ch = CH_NONE;
    if (code7 < 7'(MapSize)) begin
      map_ch = (shift_q || caps_q) ? SHIFT_MAP[6'(code7)] : PLAIN_MAP[6'(code7)];
    end
  end

  // classify the beat
  always_comb begin
    shift_d            = shift_q;
    caps_d             = caps_q;
    q_push_o           = 1'b0;
    q_cmd_o.op         = CMD_PUT;
    q_cmd_o.char_code  = map_ch;
    q_cmd_o.max_length = max_length_i;
    if (accept) begin
      if (op_i) begin
        q_push_o   = 1'b1;
        q_cmd_o.op = CMD_READ;
      end else if ((scan_code_i & SC_BREAK_BIT) != 8'h00) begin
        if (code7 == SC_LSHIFT || code7 == SC_RSHIFT) begin
          shift_d = 1'b0;
        end
      end else if (code7 == SC_LSHIFT || code7 == SC_RSHIFT) begin
        shift_d = 1'b1;
      end else if (code7 == SC_CAPS) begin
        caps_d = !caps_q;
      end else if (code7 == SC_CTRL || code7 == SC_ALT) begin
        q_push_o = 1'b0;
      end else if (map_ch != CH_NONE) begin
        q_push_o = 1'b1;
        priority if (map_ch == CH_ENTER) begin
          q_cmd_o.op = CMD_ENTER;
        end else if (map_ch == CH_BKSP) begin
          q_cmd_o.op = CMD_BKSP;
        end else begin
          q_cmd_o.op = CMD_PUT;
        end
      end
    end
  end

  // modifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

>>> rtl/core/kscle_queue.sv
// short command queue between front and back
module kscle_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kscle_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output kscle_pkg::cmd_t cmd_o
);
  import kscle_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/kscle_back.sv
// back end: line store, fill count, readout and the output register
module kscle_back #(
  parameter int unsigned LINE_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  kscle_pkg::cmd_t              q_cmd_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kscle_pkg::KindW-1:0]  kind_o,
  output logic [kscle_pkg::CharW-1:0]  char_code_o,
  output logic [kscle_pkg::LenW-1:0]   length_o,
  output logic                         ready_res_o,
  output logic                         last_o
);
  import kscle_pkg::*;

  localparam int unsigned CW = $clog2(LINE_SIZE);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [CharW-1:0] mem [LINE_SIZE];

  logic             state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             line_rdy_q, line_rdy_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CharW-1:0] rd_data_q;
  logic [CW-1:0]    rd_addr;
  logic             mem_we;

  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [CharW-1:0] char_q, char_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             rdy_q, rdy_d;
  logic             last_q, last_d;

  logic             out_free;
  logic [MaxW-1:0]  lim;
  logic [CW-1:0]    n_calc;
  logic             rd_last;

  assign out_free = !out_valid_q || out_ready_i;

  // characters to return: max_length less one, limited by the fill count
  assign lim    = (q_cmd_i.max_length == '0) ? '0 : q_cmd_i.max_length - 1'b1;
  assign n_calc = (lim < MaxW'(fill_q)) ? CW'(lim) : fill_q;
  assign rd_last = (idx_q + 1'b1 == n_q);

  // command execution
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    line_rdy_d  = line_rdy_q;
    idx_d       = idx_q;
    n_d         = n_q;
    rd_addr     = '0;
    mem_we      = 1'b0;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    char_d      = char_q;
    len_d       = len_q;
    rdy_d       = rdy_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          kind_d  = KIND_ECHO;
          char_d  = q_cmd_i.char_code;
          len_d   = '0;
          rdy_d   = 1'b0;
          last_d  = 1'b1;
          unique case (q_cmd_i.op)
            CMD_PUT: begin
              if (fill_q < CW'(LINE_SIZE - 1)) begin
                mem_we      = 1'b1;
                fill_d      = fill_q + 1'b1;
                out_valid_d = 1'b1;
              end
            end
            CMD_BKSP: begin
              if (fill_q != '0) begin
                fill_d      = fill_q - 1'b1;
                char_d      = CH_BKSP;
                out_valid_d = 1'b1;
              end
            end
            CMD_ENTER: begin
              line_rdy_d  = 1'b1;
              char_d      = CH_ENTER;
              out_valid_d = 1'b1;
            end
            CMD_READ: begin
              kind_d = KIND_STATUS;
              char_d = CH_NONE;
              if (!line_rdy_q) begin
                out_valid_d = 1'b1;
              end else if (n_calc == '0) begin
                rdy_d       = 1'b1;
                out_valid_d = 1'b1;
                fill_d      = '0;
                line_rdy_d  = 1'b0;
              end else begin
                n_d     = n_calc;
                idx_d   = '0;
                state_d = ST_READ;
              end
            end
            default: begin
              out_valid_d = out_valid_q && !out_ready_i;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_addr = idx_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_CMD;
          char_d      = rd_data_q;
          rdy_d       = 1'b1;
          last_d      = rd_last;
          len_d       = rd_last ? LenW'(n_q) : '0;
          idx_d       = idx_q + 1'b1;
          rd_addr     = idx_q + 1'b1;
          if (rd_last) begin
            state_d    = ST_IDLE;
            fill_d     = '0;
            line_rdy_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      line_rdy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      line_rdy_q  <= line_rdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // readout position and output payload
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    n_q    <= n_d;
    kind_q <= kind_d;
    char_q <= char_d;
    len_q  <= len_d;
    rdy_q  <= rdy_d;
    last_q <= last_d;
  end

  // line store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q] <= q_cmd_i.char_code;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_code_o = char_q;
  assign length_o    = len_q;
  assign ready_res_o = rdy_q;
  assign last_o      = last_q;

endmodule

>>> rtl/core/keyboard_scan_code_line_editor.sv
// top level of the scan code set 1 line editor
//
// Input channel (in_valid_i / in_ready_o): one beat is either a keyboard byte
// (op_i = 0, scan_code_i) or a read request for the finished line
// (op_i = 1, max_length_i). Output channel (out_valid_o / out_ready_i): echo
// characters, command characters and status beats, last_o on the final one.
// The front end tracks shift and caps lock and maps keys; it queues at most
// two commands for the back end, which holds the line store. Keys that give
// no result (releases, modifiers, unmapped codes) are absorbed at the front.
// A keystroke echo passes through the command queue and the output register.
// A read of n characters passes through the command queue and the read
// state, then delivers one character a cycle from the registered line store
// port while the receiver does not stall.
// While the receiver stalls, the output register holds its beat; the queue
// fills and in_ready_o drops once two commands are waiting.
// Reset clears shift, caps lock, the fill count, the ready flag and the
// queue; the line store itself is not cleared and needs no sweep.
module keyboard_scan_code_line_editor #(
  parameter int unsigned LINE_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [7:0]                   scan_code_i,
  input  logic [kscle_pkg::MaxW-1:0]   max_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kscle_pkg::KindW-1:0]  kind_o,
  output logic [kscle_pkg::CharW-1:0]  char_code_o,
  output logic [kscle_pkg::LenW-1:0]   length_o,
  output logic                         ready_res_o,
  output logic                         last_o
);
  import kscle_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_wr_cmd, q_rd_cmd;

  // key classification
  kscle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .scan_code_i  (scan_code_i),
    .max_length_i (max_length_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_wr_cmd)
  );

  // command queue
  kscle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_rd_cmd)
  );

  // line store and result generation
  kscle_back #(
    .LINE_SIZE (LINE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_rd_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .char_code_o (char_code_o),
    .length_o    (length_o),
    .ready_res_o (ready_res_o),
    .last_o      (last_o)
  );

endmodule
